// ----- hw/rtl/data_directive_literal_parser_top_macros.svh -----
// assertion macros for the data directive literal parser
`ifndef DATA_DIRECTIVE_LITERAL_PARSER_TOP_MACROS_SVH
`define DATA_DIRECTIVE_LITERAL_PARSER_TOP_MACROS_SVH

`ifndef SYNTH
`define DDLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DDLP_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  `DDLP_ASSERT(lbl, clk, rstn, !(prop), msg)
`else
`define DDLP_ASSERT(lbl, clk, rstn, prop, msg)
`define DDLP_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

// ----- hw/rtl/ddlp_pkg.sv -----
// types, constants and helpers shared by the literal parser modules
`default_nettype none

package ddlp_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_CMT  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  localparam logic [1:0] WidthByte = 2'd0;
  localparam logic [1:0] WidthHalf = 2'd1;

  localparam logic [7:0] CharHex  = 8'h24;
  localparam logic [7:0] CharDec  = 8'h23;
  localparam logic [7:0] CharBin  = 8'h25;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharNl   = 8'h0A;

  localparam logic [4:0] NoDigit = 5'd16;

  // one literal to be sent out as bytes
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  width_sel;
    logic        bad;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [4:0] d;
    d = NoDigit;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return d;
  endfunction

  function automatic logic [1:0] last_index(logic [1:0] wsel);
    logic [1:0] idx;
    unique case (wsel)
      WidthByte: idx = 2'd0;
      WidthHalf: idx = 2'd1;
      default:   idx = 2'd3;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/data_directive_literal_parser_top.sv -----
// top level of the data directive literal parser
// usage:
//   input channel: one character (ch_i) with its element size (width_sel_i)
//   per transfer, in_valid_i / in_stall_o; a transfer takes place when valid
//   is high and stall is low
//   output channel: one literal byte per transfer, least significant first,
//   with last_byte_o on the final byte and bad_literal_o on every byte,
//   out_valid_o / out_stall_i
//   throughput: one character per cycle while in_stall_o is low and one byte
//   per cycle while out_stall_i is low; the parser takes characters while
//   the serializer is still sending earlier literals
//   a literal is queued on the transfer of the character that ends it; its
//   first byte is valid once the serializer has loaded it from the queue
//   a queue of QueueDepth literals sits between parser and serializer; when
//   it is full in_stall_o is high, so a long out_stall_i backs up to the input
//   while out_stall_i is high the current byte and its flags hold
//   reset: parser idle, queue empty, no output valid
`default_nettype none

`include "data_directive_literal_parser_top_macros.svh"

module data_directive_literal_parser_top import ddlp_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  logic [1:0] width_sel_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic [7:0] data_byte_o,
  output logic       last_byte_o,
  output logic       bad_literal_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  qstat_t qstat;
  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   head_cmd;

  ddlp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (ch_i),
    .width_sel_i (width_sel_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .qstat_i     (qstat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  ddlp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (qstat)
  );

  ddlp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .data_byte_o   (data_byte_o),
    .last_byte_o   (last_byte_o),
    .bad_literal_o (bad_literal_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

  `DDLP_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && qstat.full, "push into full queue")
  `DDLP_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && qstat.empty, "pop from empty queue")
  `DDLP_ASSERT(a_idle_after_last, clk_i, rst_ni,
    out_valid_o && last_byte_o && !out_stall_i && qstat.empty |=> !out_valid_o,
    "output valid after last byte with nothing queued")

endmodule

`default_nettype wire

// ----- hw/rtl/ddlp_front.sv -----
// front end: character parser that builds literal values and queues them
`default_nettype none

module ddlp_front import ddlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ch_i,
  input  logic [1:0] width_sel_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  qstat_t     qstat_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  mode_e       mode_q, mode_d;
  radix_e      radix_q, radix_d;
  logic [31:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic        xfer;
  logic        emit;
  logic [4:0]  dig;
  logic        in_lit_digit;

  assign in_stall_o = qstat_i.full;
  assign xfer       = in_valid_i && !qstat_i.full;
  assign dig        = digit_of(ch_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      radix_q <= RADIX_BIN;
      acc_q   <= 32'd0;
      err_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      radix_q <= radix_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    radix_d      = radix_q;
    acc_d        = acc_q;
    err_d        = err_q;
    emit         = 1'b0;
    in_lit_digit = (mode_q == MODE_LIT) && (dig != NoDigit);
    if (xfer) begin
      if (in_lit_digit) begin
        unique case (radix_q)
          RADIX_HEX: acc_d = {acc_q[27:0], dig[3:0]};
          RADIX_DEC: begin
            if (dig < 5'd10) begin
              acc_d = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, dig[3:0]};
            end else begin
              err_d = 1'b1;
            end
          end
          default: begin
            if (dig < 5'd2) begin
              acc_d = {acc_q[30:0], dig[0]};
            end else begin
              err_d = 1'b1;
            end
          end
        endcase
      end else if (mode_q == MODE_CMT) begin
        if (ch_i == CharNl) begin
          mode_d = MODE_IDLE;
        end
      end else begin
        emit = (mode_q == MODE_LIT);
        if (ch_i == CharHex || ch_i == CharDec || ch_i == CharBin) begin
          mode_d  = MODE_LIT;
          radix_d = (ch_i == CharHex) ? RADIX_HEX :
                    (ch_i == CharDec) ? RADIX_DEC : RADIX_BIN;
          acc_d   = 32'd0;
          err_d   = 1'b0;
        end else if (ch_i == CharSemi) begin
          mode_d = MODE_CMT;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
    end
  end

  assign push_o          = emit;
  assign cmd_o.value     = acc_q;
  assign cmd_o.width_sel = width_sel_i;
  assign cmd_o.bad       = err_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ddlp_queue.sv -----
// short command queue between the parser and the byte serializer
`default_nettype none

module ddlp_queue import ddlp_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cmd_t   cmd_i,
  input  logic   pop_i,
  output cmd_t   cmd_o,
  output qstat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/ddlp_back.sv -----
// back end: sends each queued literal out as little-endian bytes
`default_nettype none

module ddlp_back import ddlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qstat_t     qstat_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic [7:0] data_byte_o,
  output logic       last_byte_o,
  output logic       bad_literal_o,
  output logic       out_valid_o,
  input  logic       out_stall_i
);

  logic       active_q;
  cmd_t       cmd_q;
  logic [1:0] idx_q;
  logic       out_xfer;
  logic       last;

  assign last     = (idx_q == last_index(cmd_q.width_sel));
  assign out_xfer = active_q && !out_stall_i;
  assign pop_o    = (!active_q || (out_xfer && last)) && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= 2'd0;
      end else if (out_xfer) begin
        if (last) begin
          active_q <= 1'b0;
        end
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  assign out_valid_o   = active_q;
  assign data_byte_o   = cmd_q.value[{idx_q, 3'b000} +: 8];
  assign last_byte_o   = last;
  assign bad_literal_o = cmd_q.bad;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the data directive literal parser top level
module testbench;
  import ddlp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } lit_byte_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [1:0]  wsel;
    logic        typed;
    logic [2:0]  count;
    logic [31:0] value;
    logic        bad;
  } script_row_t;

  localparam int IdlePct [4] = '{0, 68, 0, 31};
  localparam int StallPct [4] = '{0, 0, 68, 31};
  localparam int ItemsPerPhase = 68;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 8;

  // typed rows carry their expected literal, the others go through the predictor
  localparam script_row_t Script [22] = '{
    '{CharHex,  2'd0, 1'b1, 3'd0, 32'h0,  1'b0},
    '{"f",      2'd0, 1'b0, 3'd0, 32'h0,  1'b0},
    '{"F",      2'd1, 1'b0, 3'd0, 32'h0,  1'b0},
    '{CharNl,   2'd2, 1'b1, 3'd4, 32'hFF, 1'b0},
    '{CharDec,  2'd0, 1'b1, 3'd0, 32'h0,  1'b0},
    '{"9",      2'd3, 1'b0, 3'd0, 32'h0,  1'b0},
    '{"a",      2'd0, 1'b0, 3'd0, 32'h0,  1'b0},
    '{CharSemi, 2'd1, 1'b1, 3'd2, 32'd9,  1'b1},
    '{CharHex,  2'd0, 1'b0, 3'd0, 32'h0,  1'b0},
    '{CharNl,   2'd2, 1'b0, 3'd0, 32'h0,  1'b0},
    '{CharBin,  2'd0, 1'b0, 3'd0, 32'h0,  1'b0},
    '{"1",      2'd0, 1'b0, 3'd0, 32'h0,  1'b0},
    '{"2",      2'd1, 1'b0, 3'd0, 32'h0,  1'b0},
    '{"0",      2'd2, 1'b0, 3'd0, 32'h0,  1'b0},
    '{CharDec,  2'd3, 1'b1, 3'd4, 32'd2,  1'b1},
    '{"z",      2'd0, 1'b1, 3'd1, 32'd0,  1'b0},
    '{8'hFF,    2'd3, 1'b1, 3'd0, 32'h0,  1'b0},
    '{8'h00,    2'd0, 1'b1, 3'd0, 32'h0,  1'b0},
    '{CharHex,  2'd1, 1'b0, 3'd0, 32'h0,  1'b0},
    '{"A",      2'd0, 1'b0, 3'd0, 32'h0,  1'b0},
    '{"5",      2'd2, 1'b0, 3'd0, 32'h0,  1'b0},
    '{",",      2'd0, 1'b1, 3'd1, 32'hA5, 1'b0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] ch_i = 8'h00;
  logic [1:0] width_sel_i = 2'd0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_o;
  logic       last_byte_o;
  logic       bad_literal_o;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;

  lit_byte_t   pending_bytes [$];
  int          phase = 0;
  int          fault_count = 0;
  int unsigned chars_sent = 0;

  mode_e       lit_mode = MODE_IDLE;
  radix_e      lit_radix = RADIX_BIN;
  logic [31:0] lit_value = 32'h0;
  logic        lit_bad = 1'b0;

  data_directive_literal_parser_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ch_i         (ch_i),
    .width_sel_i  (width_sel_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_o  (data_byte_o),
    .last_byte_o  (last_byte_o),
    .bad_literal_o(bad_literal_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [4:0] char_digit(logic [7:0] c);
    logic [4:0] d;
    d = NoDigit;
    if (c inside {["0":"9"]}) begin
      d = 5'(c - "0");
    end else if (c inside {["a":"f"]}) begin
      d = 5'(c - "a" + 8'd10);
    end else if (c inside {["A":"F"]}) begin
      d = 5'(c - "A" + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = "0" + {4'h0, v};
    end else begin
      c = ($urandom_range(1) ? "A" : "a") + {4'h0, v} - 8'd10;
    end
    return c;
  endfunction

  // advances the parser state; n bytes of val are due when a literal closes
  task automatic parse_char(input logic [7:0] c, input logic [1:0] wsel, output int n,
                            output logic [31:0] val, output logic bad);
    logic [4:0] d;
    n = 0;
    val = lit_value;
    bad = lit_bad;
    d = char_digit(c);
    if (lit_mode == MODE_LIT) begin
      if (d != NoDigit) begin
        case (lit_radix)
          RADIX_HEX: lit_value = {lit_value[27:0], d[3:0]};
          RADIX_DEC: begin
            if (d < 5'd10) lit_value = lit_value * 32'd10 + {27'h0, d};
            else lit_bad = 1'b1;
          end
          default: begin
            if (d < 5'd2) lit_value = {lit_value[30:0], d[0]};
            else lit_bad = 1'b1;
          end
        endcase
        return;
      end
      n = (wsel == WidthByte) ? 1 : (wsel == WidthHalf) ? 2 : 4;
      val = lit_value;
      bad = lit_bad;
      lit_mode = MODE_IDLE;
    end
    if (lit_mode == MODE_CMT) begin
      if (c == CharNl) lit_mode = MODE_IDLE;
    end else if (c == CharHex || c == CharDec || c == CharBin) begin
      lit_mode = MODE_LIT;
      lit_radix = (c == CharHex) ? RADIX_HEX : (c == CharDec) ? RADIX_DEC : RADIX_BIN;
      lit_value = 32'h0;
      lit_bad = 1'b0;
    end else if (c == CharSemi) begin
      lit_mode = MODE_CMT;
    end else begin
      lit_mode = MODE_IDLE;
    end
  endtask

  task automatic push_literal(input int n, input logic [31:0] val, input logic bad);
    for (int k = 0; k < n; k++) begin
      pending_bytes.push_back('{val[8*k +: 8], k == n - 1, bad});
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_char(input logic [7:0] c, input logic [1:0] w, output int n,
                           output logic [31:0] val, output logic bad);
    while ($urandom_range(99) < IdlePct[phase]) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    width_sel_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    parse_char(c, w, n, val, bad);
    @(negedge clk_i);
  endtask

  task automatic feed(input logic [7:0] c);
    int n;
    logic [31:0] val;
    logic bad;
    send_char(c, 2'($urandom_range(3)), n, val, bad);
    push_literal(n, val, bad);
  endtask

  task automatic comment_tail();
    repeat ($urandom_range(4)) feed(8'($urandom_range(255)));
    feed(CharNl);
  endtask

  task automatic random_literal();
    int unsigned pick;
    int unsigned len;
    radix_e r;
    logic [3:0] dv;
    pick = $urandom_range(2);
    r = (pick == 0) ? RADIX_HEX : (pick == 1) ? RADIX_DEC : RADIX_BIN;
    feed((pick == 0) ? CharHex : (pick == 1) ? CharDec : CharBin);
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8);
    repeat (len) begin
      if ($urandom_range(9) == 0 || r == RADIX_HEX) dv = 4'($urandom_range(15));
      else if (r == RADIX_DEC) dv = 4'($urandom_range(9));
      else dv = 4'($urandom_range(1));
      feed(digit_char(dv));
    end
    case ($urandom_range(9))
      0, 1: feed(",");
      2: feed(" ");
      3: feed(CharNl);
      4: begin
        feed(CharSemi);
        comment_tail();
      end
      5: feed(CharDec);
      default: feed(8'($urandom_range(255)));
    endcase
  endtask

  task automatic drain_pause();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic flag_error(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < StallPct[phase]);
  end

  always @(posedge clk_i) begin : check_out
    lit_byte_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %h last %b bad %b",
                             data_byte_o, last_byte_o, bad_literal_o));
      end else begin
        exp = pending_bytes.pop_front();
        if (data_byte_o !== exp.data)
          flag_error($sformatf("data_byte expected %h got %h", exp.data, data_byte_o));
        if (last_byte_o !== exp.last)
          flag_error($sformatf("last_byte expected %b got %b", exp.last, last_byte_o));
        if (bad_literal_o !== exp.bad)
          flag_error($sformatf("bad_literal expected %b got %b", exp.bad, bad_literal_o));
      end
    end
  end

  // ends the run after too many cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    int n;
    logic [31:0] val;
    logic bad;
    int unsigned target;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (Script[i]) begin
      send_char(Script[i].ch, Script[i].wsel, n, val, bad);
      if (Script[i].typed) push_literal(int'(Script[i].count), Script[i].value, Script[i].bad);
      else push_literal(n, val, bad);
    end
    for (int p = 0; p < 4; p++) begin
      drain_pause();
      phase = p;
      target = chars_sent + ItemsPerPhase;
      while (chars_sent < target) begin
        case ($urandom_range(9))
          0: feed(8'($urandom_range(255)));
          1: begin
            feed(CharSemi);
            comment_tail();
          end
          default: random_literal();
        endcase
      end
    end
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0 && pending_bytes.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ddlp_pkg.sv
hw/rtl/ddlp_front.sv
hw/rtl/ddlp_queue.sv
hw/rtl/ddlp_back.sv
hw/rtl/data_directive_literal_parser_top.sv
bench/testbench.sv
